// ===== hw/rtl/phdc_pkg.sv =====
// Shared types and constants for the PID heater duty controller.
// No dependencies; imported by phdc_error_stage and the top level.
`default_nettype none

package phdc_pkg;

  localparam int TARGET_W   = 13;
  localparam int MEASURED_W = 14;
  localparam int ERR_W      = 14;
  localparam int SUM_W      = 16;
  localparam int DERR_W     = 15;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int DUTY_W     = 16;
  localparam int DUTY_SHIFT = 10;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 16'd33333;

  typedef logic [1:0] reg_index_t;

  localparam reg_index_t REG_GAIN_P         = 2'd0;
  localparam reg_index_t REG_GAIN_I         = 2'd1;
  localparam reg_index_t REG_GAIN_D         = 2'd2;
  localparam reg_index_t REG_INTEGRAL_LIMIT = 2'd3;

  // Error terms of one request, handed from the error stage to the multipliers.
  typedef struct packed {
    logic                     en;
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DERR_W-1:0] derr;
  } err_terms_t;

endpackage

`default_nettype wire

// ===== hw/rtl/phdc_error_stage.sv =====
// Error, clamped integral and error difference; owns the integral and
// last-error state. Depends on phdc_pkg.
`default_nettype none

module phdc_error_stage (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load,
  input  wire logic                              heat_enable,
  input  wire logic [phdc_pkg::TARGET_W-1:0]     target_temp,
  input  wire logic [phdc_pkg::MEASURED_W-1:0]   measured_temp,
  input  wire logic [phdc_pkg::LIMIT_W-1:0]      integral_limit,
  output phdc_pkg::err_terms_t                   terms
);
  import phdc_pkg::*;

  logic signed [SUM_W-1:0]  error_sum;
  logic signed [SUM_W-1:0]  error_sum_next;
  logic signed [ERR_W-1:0]  previous_error;
  logic signed [ERR_W-1:0]  err;
  logic signed [15:0]       err_wide;
  logic signed [16:0]       sum_wide;
  logic signed [16:0]       lim_pos;
  logic signed [16:0]       lim_neg;

  always_comb begin
    err_wide = $signed({3'b000, target_temp})
             - $signed({{2{measured_temp[MEASURED_W-1]}}, measured_temp});
    // saturate to the 14-bit error range
    if (err_wide > 16'sd8191) begin
      err = 14'sh1FFF;
    end else if (err_wide < -16'sd8192) begin
      err = 14'sh2000;
    end else begin
      err = err_wide[ERR_W-1:0];
    end

    sum_wide = {error_sum[SUM_W-1], error_sum} + {{3{err[ERR_W-1]}}, err};
    lim_pos  = $signed({2'b00, integral_limit});
    lim_neg  = -lim_pos;
    if (sum_wide > lim_pos) begin
      error_sum_next = lim_pos[SUM_W-1:0];
    end else if (sum_wide < lim_neg) begin
      error_sum_next = lim_neg[SUM_W-1:0];
    end else begin
      error_sum_next = sum_wide[SUM_W-1:0];
    end

    terms.en   = heat_enable;
    terms.err  = err;
    terms.sum  = error_sum_next;
    terms.derr = {err[ERR_W-1], err} - {previous_error[ERR_W-1], previous_error};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (load) begin
      if (heat_enable) begin
        error_sum      <= error_sum_next;
        previous_error <= err;
      end else begin
        // heater off: drop the integral, hold the last error
        error_sum <= '0;
      end
    end
  end

  a_off_clears_sum: assert property (@(posedge clk) disable iff (rst)
    load && !heat_enable |=> error_sum == '0)
    else $error("integral not cleared with heater off");

  a_off_holds_last_err: assert property (@(posedge clk) disable iff (rst)
    load && !heat_enable |=> $stable(previous_error))
    else $error("last error changed with heater off");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(error_sum) && $stable(previous_error))
    else $error("state changed without a request");

endmodule

`default_nettype wire

// ===== hw/rtl/pid_heater_duty_control_unit.sv =====
// PID heater duty controller: four-stage pipeline (input, error, multiply, sum).
// Throughput 1 request/cycle while the output is not stalled.
// Each stage holds its request while the next is full and stalled; bubbles collapse.
// The integral and last-error state update as a request leaves the input register.
// rst (synchronous) clears gains, limit, integral, last error and all valid bits.
`default_nettype none

module pid_heater_duty_control_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire phdc_pkg::reg_index_t              cfg_index,
  input  wire logic [phdc_pkg::GAIN_W-1:0]       cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              heat_enable,
  input  wire logic [phdc_pkg::TARGET_W-1:0]     target_temp,
  input  wire logic [phdc_pkg::MEASURED_W-1:0]   measured_temp,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [phdc_pkg::DUTY_W-1:0]            duty
);
  import phdc_pkg::*;

  logic [GAIN_W-1:0]  gain_p;
  logic [GAIN_W-1:0]  gain_i;
  logic [GAIN_W-1:0]  gain_d;
  logic [LIMIT_W-1:0] integral_limit;

  // stage 1: input register
  logic                  s1_valid;
  logic                  s1_en;
  logic [TARGET_W-1:0]   s1_target;
  logic [MEASURED_W-1:0] s1_measured;
  // stage 2: error terms
  logic                  s2_valid;
  err_terms_t            s2_terms;
  err_terms_t            terms_next;
  // stage 3: products
  logic                  s3_valid;
  logic                  s3_en;
  logic signed [30:0]    prod_p;
  logic signed [32:0]    prod_i;
  logic signed [31:0]    prod_d;
  logic signed [30:0]    prod_p_next;
  logic signed [32:0]    prod_i_next;
  logic signed [31:0]    prod_d_next;
  // stage 4: sum, shift, clamp
  logic signed [34:0]    total;
  logic [23:0]           shifted;
  logic [DUTY_W-1:0]     duty_next;

  logic ready1, ready2, ready3, ready4;

  assign ready4   = !out_valid || !out_stall;
  assign ready3   = !s3_valid || ready4;
  assign ready2   = !s2_valid || ready3;
  assign ready1   = !s1_valid || ready2;
  assign in_stall = !ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_limit <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:         gain_p         <= cfg_data;
        REG_GAIN_I:         gain_i         <= cfg_data;
        REG_GAIN_D:         gain_d         <= cfg_data;
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready1) begin
      s1_valid <= in_valid;
    end
    if (in_valid && ready1) begin
      s1_en       <= heat_enable;
      s1_target   <= target_temp;
      s1_measured <= measured_temp;
    end
  end

  phdc_error_stage u_error_stage (
    .clk            (clk),
    .rst            (rst),
    .load           (s1_valid && ready2),
    .heat_enable    (s1_en),
    .target_temp    (s1_target),
    .measured_temp  (s1_measured),
    .integral_limit (integral_limit),
    .terms          (terms_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= s1_valid;
    end
    if (s1_valid && ready2) begin
      s2_terms <= terms_next;
    end
  end

  always_comb begin
    prod_p_next = 31'($signed({1'b0, gain_p})) * 31'(s2_terms.err);
    prod_i_next = 33'($signed({1'b0, gain_i})) * 33'(s2_terms.sum);
    prod_d_next = 32'($signed({1'b0, gain_d})) * 32'(s2_terms.derr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (ready3) begin
      s3_valid <= s2_valid;
    end
    if (s2_valid && ready3) begin
      s3_en  <= s2_terms.en;
      prod_p <= prod_p_next;
      prod_i <= prod_i_next;
      prod_d <= prod_d_next;
    end
  end

  always_comb begin
    total = {{4{prod_p[30]}}, prod_p} + {{2{prod_i[32]}}, prod_i}
          + {{3{prod_d[31]}}, prod_d};
    shifted = total[DUTY_SHIFT+23:DUTY_SHIFT];
    if (!s3_en || total[34]) begin
      duty_next = '0;
    end else if (shifted > {8'd0, DUTY_MAX}) begin
      duty_next = DUTY_MAX;
    end else begin
      duty_next = shifted[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready4) begin
      out_valid <= s3_valid;
    end
    if (s3_valid && ready4) begin
      duty <= duty_next;
    end
  end

  a_duty_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> duty <= DUTY_MAX)
    else $error("duty above saturation limit");

  a_accept_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with empty input register");

  a_off_gives_zero: assert property (@(posedge clk) disable iff (rst)
    s3_valid && ready4 && !s3_en |=> duty == '0)
    else $error("nonzero duty with heater off");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    s3_valid && !ready4 |=> s3_valid && $stable(prod_p) && $stable(prod_i))
    else $error("product stage overwritten while stalled");

endmodule

`default_nettype wire

// ===== verif/pid_heater_duty_control_unit_test.sv =====
// Self-checking testbench for pid_heater_duty_control_unit: a directed table, then random phases.
// Depends on phdc_pkg and the unit RTL; duty is predicted by a PID model kept in this bench.
module pid_heater_duty_control_unit_test;
  import phdc_pkg::*;

  localparam int CYCLE_LIMIT    = 300000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 6;
  localparam int PHASE_REQUESTS = 125;
  localparam int PLAN_ROWS      = 28;
  localparam int ERR_HI         = (1 << (ERR_W - 1)) - 1;
  localparam int ERR_LO         = -(1 << (ERR_W - 1));
  localparam int MEAS_HI        = (1 << (MEASURED_W - 1)) - 1;
  localparam int MEAS_LO        = -(1 << (MEASURED_W - 1));
  localparam int LIMIT_MAX      = (1 << LIMIT_W) - 1;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    reg_index_t                   index;
    logic [GAIN_W-1:0]            value;
    logic                         en;
    logic [TARGET_W-1:0]          target;
    logic signed [MEASURED_W-1:0] measured;
    logic                         known;
    logic [DUTY_W-1:0]            known_duty;
  } plan_row_t;

  // Duty is typed in where it is plain: zero gains, heater off, full saturation, negative sum.
  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd0, 14'sd0, 1'b1, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd8191, -14'sd8192, 1'b1, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b0, 13'd5000, -14'sd500, 1'b1, 16'd0},
    '{ROW_WRITE, REG_GAIN_P, 16'd65535, 1'b0, 13'd0, 14'sd0, 1'b0, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd8191, -14'sd8192, 1'b1, DUTY_MAX},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd0, 14'sd8191, 1'b1, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b0, 13'd0, 14'sd0, 1'b1, 16'd0},
    '{ROW_WRITE, REG_GAIN_P, 16'd1024, 1'b0, 13'd0, 14'sd0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_GAIN_I, 16'd1024, 1'b0, 13'd0, 14'sd0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_GAIN_D, 16'd1024, 1'b0, 13'd0, 14'sd0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_INTEGRAL_LIMIT, 16'd32767, 1'b0, 13'd0, 14'sd0, 1'b0, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd1000, 14'sd900, 1'b0, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd1000, 14'sd950, 1'b0, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd1000, 14'sd1000, 1'b0, 16'd0},
    // error beyond the 14 bit range saturates
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd0, -14'sd8192, 1'b0, 16'd0},
    // drive the integral into its clamp
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd8191, -14'sd8192, 1'b0, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd8191, -14'sd8192, 1'b0, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd8191, -14'sd8192, 1'b0, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd5000, -14'sd500, 1'b0, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b0, 13'd5000, -14'sd500, 1'b0, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd0, 14'sd8191, 1'b0, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd2500, 14'sd2600, 1'b0, 16'd0},
    '{ROW_WRITE, REG_INTEGRAL_LIMIT, 16'd0, 1'b0, 13'd0, 14'sd0, 1'b0, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd3000, 14'sd2000, 1'b0, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd3000, 14'sd2990, 1'b0, 16'd0},
    '{ROW_WRITE, REG_GAIN_D, 16'd65535, 1'b0, 13'd0, 14'sd0, 1'b0, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd100, -14'sd100, 1'b0, 16'd0},
    '{ROW_REQUEST, REG_GAIN_P, 16'd0, 1'b1, 13'd100, 14'sd300, 1'b0, 16'd0}
  };

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_we        = 1'b0;
  reg_index_t            cfg_index     = REG_GAIN_P;
  logic [GAIN_W-1:0]     cfg_data      = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic                  heat_enable   = 1'b0;
  logic [TARGET_W-1:0]   target_temp   = '0;
  logic [MEASURED_W-1:0] measured_temp = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b1;
  logic [DUTY_W-1:0]     duty;

  // Controller mirror: gains, clamp, integral and last error.
  int kp_gain     = 0;
  int ki_gain     = 0;
  int kd_gain     = 0;
  int integ_limit = 0;
  int integ_sum   = 0;
  int last_err    = 0;

  logic [DUTY_W-1:0] duty_expected_q [$];
  logic [DUTY_W-1:0] want_duty;
  int                error_count  = 0;
  int unsigned       cycle_count  = 0;
  bit                steady_flow  = 1'b0;
  bit                hold_results = 1'b0;

  pid_heater_duty_control_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .heat_enable  (heat_enable),
    .target_temp  (target_temp),
    .measured_temp(measured_temp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .duty         (duty)
  );

  always #2 clk = ~clk;

  function automatic logic [DUTY_W-1:0] predict_duty(input logic en,
      input logic [TARGET_W-1:0] tgt, input logic signed [MEASURED_W-1:0] meas);
    int     err;
    int     sum;
    longint total;
    if (!en) begin
      integ_sum = 0;
      return '0;
    end
    err = int'(tgt) - int'(meas);
    if (err > ERR_HI) err = ERR_HI;
    if (err < ERR_LO) err = ERR_LO;
    sum = integ_sum + err;
    if (sum > integ_limit) sum = integ_limit;
    else if (sum < -integ_limit) sum = -integ_limit;
    integ_sum = sum;
    total = longint'(kp_gain) * longint'(err) + longint'(ki_gain) * longint'(sum)
          + longint'(kd_gain) * longint'(err - last_err);
    last_err = err;
    if (total < 0) return '0;
    total = total >>> DUTY_SHIFT;
    if (total > longint'(DUTY_MAX)) return DUTY_MAX;
    return total[DUTY_W-1:0];
  endfunction

  function automatic logic [GAIN_W-1:0] draw_gain();
    if ($urandom_range(0, 7) == 0) return GAIN_W'($urandom_range(0, 65535));
    return GAIN_W'($urandom_range(0, 3072));
  endfunction

  // Entered and left at a falling edge; holds the request until it is taken.
  task automatic send_request(input logic en, input logic [TARGET_W-1:0] tgt,
      input logic signed [MEASURED_W-1:0] meas, input logic known,
      input logic [DUTY_W-1:0] known_duty);
    int                gap;
    logic [DUTY_W-1:0] predicted;
    gap = steady_flow ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    heat_enable   <= en;
    target_temp   <= tgt;
    measured_temp <= meas;
    do @(posedge clk); while (in_stall);
    predicted = predict_duty(en, tgt, meas);
    duty_expected_q.push_back(known ? known_duty : predicted);
    @(negedge clk);
  endtask

  task automatic send_random_request();
    logic                en;
    logic [TARGET_W-1:0] tgt;
    int                  meas;
    en = ($urandom_range(0, 19) != 0);
    if ($urandom_range(0, 3) == 0) tgt = TARGET_W'($urandom_range(0, 8191));
    else tgt = TARGET_W'($urandom_range(0, 5000));
    // mostly a measurement that tracks the setpoint, now and then anything
    if ($urandom_range(0, 3) == 0) meas = int'($urandom_range(0, 16383)) - 8192;
    else meas = int'(tgt) + int'($urandom_range(0, 400)) - 200;
    if (meas > MEAS_HI) meas = MEAS_HI;
    if (meas < MEAS_LO) meas = MEAS_LO;
    send_request(en, tgt, MEASURED_W'(meas), 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (duty_expected_q.size() != 0);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [GAIN_W-1:0] value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_GAIN_P:         kp_gain = int'(value);
      REG_GAIN_I:         ki_gain = int'(value);
      REG_GAIN_D:         kd_gain = int'(value);
      REG_INTEGRAL_LIMIT: integ_limit = int'(value[LIMIT_W-1:0]);
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int                row;
    int                phase;
    int                k;
    logic [GAIN_W-1:0] p_val;
    logic [GAIN_W-1:0] i_val;
    logic [GAIN_W-1:0] d_val;
    logic [GAIN_W-1:0] l_val;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (row = 0; row < PLAN_ROWS; row++) begin
      if (plan[row].kind == ROW_WRITE) write_reg(plan[row].index, plan[row].value);
      else send_request(plan[row].en, plan[row].target, plan[row].measured,
                        plan[row].known, plan[row].known_duty);
    end
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          p_val = '1;
          i_val = '1;
          d_val = '1;
          l_val = GAIN_W'(LIMIT_MAX);
        end
        1: begin
          p_val = GAIN_W'(1024);
          i_val = '0;
          d_val = '0;
          l_val = '0;
        end
        default: begin
          p_val = draw_gain();
          i_val = draw_gain();
          d_val = draw_gain();
          if ($urandom_range(0, 3) == 0) l_val = GAIN_W'($urandom_range(0, LIMIT_MAX));
          else l_val = GAIN_W'($urandom_range(0, 4000));
        end
      endcase
      write_reg(REG_GAIN_P, p_val);
      write_reg(REG_GAIN_I, i_val);
      write_reg(REG_GAIN_D, d_val);
      write_reg(REG_INTEGRAL_LIMIT, l_val);
      // back-to-back requests against a long result hold-off: fill the pipeline
      steady_flow = (phase == 2);
      if (phase == 2) hold_results = 1'b1;
      for (k = 0; k < PHASE_REQUESTS; k++) begin
        if (phase == 3 && k == PHASE_REQUESTS / 2) wait_drained();
        if (phase == 4) steady_flow = (k < 40);
        send_random_request();
      end
      steady_flow = 1'b0;
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) $display("** pid_heater_duty_control_unit: PASSED **");
    else $display("** pid_heater_duty_control_unit: FAILED **");
    $finish;
  end

  initial begin : result_sink
    int hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = steady_flow ? 0 : int'($urandom_range(0, 10));
      if (hold_results) begin
        hold += HOLD_CYCLES;
        hold_results = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (duty_expected_q.size() == 0) begin
        $error("duty: got %0d with no request outstanding", duty);
        error_count++;
      end else begin
        want_duty = duty_expected_q.pop_front();
        if (duty !== want_duty) begin
          $error("duty: expected %0d, actual %0d", want_duty, duty);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** pid_heater_duty_control_unit: FAILED **");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/phdc_pkg.sv
hw/rtl/phdc_error_stage.sv
hw/rtl/pid_heater_duty_control_unit.sv
verif/pid_heater_duty_control_unit_test.sv
